[src/tcf_pkg.sv]
// Shared types, constants and axis mapping functions for the touch coordinate filter.
package tcf_pkg;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_DATA_W = 4;

	localparam logic [0:0] CFG_LANDSCAPE = 1'd0;
	localparam logic [0:0] CFG_DEADBAND  = 1'd1;

	localparam logic [3:0]  DEADBAND_RESET = 4'd4;

	localparam logic [11:0] X_SPLIT    = 12'd3000;
	localparam logic [11:0] X_OFS_LOW  = 12'd3900;
	localparam logic [11:0] X_OFS_HIGH = 12'd3800;
	localparam logic [24:0] X_RECIP    = 25'd4370;
	localparam logic [7:0]  X_MAX      = 8'd239;

	localparam logic [11:0] Y_OFS      = 12'd360;
	localparam logic [24:0] Y_RECIP    = 25'd5958;
	localparam logic [8:0]  Y_MAX      = 9'd319;

	localparam logic [8:0]  BOUND_LONG  = 9'd319;
	localparam logic [8:0]  BOUND_SHORT = 9'd239;

	typedef struct packed {
		logic       was_pressed;
		logic       is_pressed;
		logic [8:0] pos_y;
		logic [7:0] pos_x;
	} res_t;

	// (3900 - raw) or (3800 - raw), /15 by reciprocal, clamp to 0..239
	function automatic logic [7:0] map_x(input logic [11:0] raw);
		logic [11:0] v;
		logic [24:0] prod;
		logic [8:0]  q;
		if (raw <= X_SPLIT) begin
			v = X_OFS_LOW - raw;
		end else if (raw < X_OFS_HIGH) begin
			v = X_OFS_HIGH - raw;
		end else begin
			v = '0;
		end
		prod = {13'd0, v} * X_RECIP;
		q = prod[24:16];
		return (q > {1'b0, X_MAX}) ? X_MAX : q[7:0];
	endfunction

	// (raw - 360) / 11 by reciprocal, clamp to 0..319
	function automatic logic [8:0] map_y(input logic [11:0] raw);
		logic [11:0] v;
		logic [24:0] prod;
		logic [8:0]  q;
		v = (raw <= Y_OFS) ? 12'd0 : (raw - Y_OFS);
		prod = {13'd0, v} * Y_RECIP;
		q = prod[24:16];
		return (q > Y_MAX) ? Y_MAX : q;
	endfunction

endpackage

[src/touch_coordinate_filter.sv]
// Touch coordinate filter top level: input register, mapping, tracking, result register.
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: raw_x, raw_y; s_tuser: touch_detected
// m        out  m_tvalid/m_tready  m_tdata: pos_x, pos_y, is_pressed, was_pressed
// cfg      in   cfg_we             cfg_index, cfg_data (0 landscape_mode, 1 deadband)
//
// One item per cycle unless m stalls; items pass the input register, then the result register.
// The held coordinates update as an item moves from the input register to the result register.
// Reset: held x 0, held y 319 (reported y 0), released, deadband 4, portrait.
// A stall on m backs up one item in the input register before s_tready drops.
module touch_coordinate_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tcf_pkg::IN_DATA_W-1:0]    s_tdata,  // raw_x[11:0], raw_y[23:12]
	input  logic [0:0]                       s_tuser,  // touch_detected[0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tcf_pkg::OUT_DATA_W-1:0]   m_tdata,  // pos_x[7:0], pos_y[16:8],
	                                                   // is_pressed[17], was_pressed[18], 0
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tcf_pkg::*;

	logic        landscape_q;
	logic [3:0]  deadband_q;

	logic        valid_s1;
	logic        touch_s1;
	logic [11:0] raw_x_s1;
	logic [11:0] raw_y_s1;

	logic        m_valid_q;
	res_t        res_q;

	logic        advance;
	logic        s_fire;
	logic [7:0]  fresh_x;
	logic [8:0]  fresh_y;
	res_t        res;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			landscape_q <= 1'b0;
			deadband_q  <= DEADBAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LANDSCAPE: landscape_q <= cfg_data[0];
				CFG_DEADBAND:  deadband_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			touch_s1 <= s_tuser[0];
			raw_x_s1 <= s_tdata[11:0];
			raw_y_s1 <= s_tdata[23:12];
		end
	end

	tcf_map u_map (
		.raw_x   (raw_x_s1),
		.raw_y   (raw_y_s1),
		.fresh_x (fresh_x),
		.fresh_y (fresh_y)
	);

	tcf_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.touch     (touch_s1),
		.fresh_x   (fresh_x),
		.fresh_y   (fresh_y),
		.landscape (landscape_q),
		.deadband  (deadband_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q.was_pressed, res_q.is_pressed, res_q.pos_y, res_q.pos_x};

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_valid_q && !m_tready))
		else $error("input stalled while result path free");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd239 && m_tdata[16:8] <= 9'd319))
		else $error("coordinate out of screen range");

	a_press_not_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17]) |-> (m_tdata[7:0] != 8'd0 && m_tdata[16:8] != 9'd0))
		else $error("pressed reported on screen edge");
`endif

endmodule

[src/tcf_map.sv]
// Raw ADC sample to screen coordinate mapping for both axes.
module tcf_map (
	input  logic [11:0] raw_x,
	input  logic [11:0] raw_y,
	output logic [7:0]  fresh_x,
	output logic [8:0]  fresh_y
);
	import tcf_pkg::*;

	assign fresh_x = map_x(raw_x);
	assign fresh_y = map_y(raw_y);

endmodule

[src/tcf_track.sv]
// Deadband hold of the coordinates and press decision.
module tcf_track (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          touch,
	input  logic [7:0]    fresh_x,
	input  logic [8:0]    fresh_y,
	input  logic          landscape,
	input  logic [3:0]    deadband,
	output tcf_pkg::res_t res
);
	import tcf_pkg::*;

	logic [7:0] held_x_q;
	logic [8:0] held_y_q;
	logic       pressed_q;

	logic [7:0] dx;
	logic [8:0] dy;
	logic [7:0] new_x;
	logic [8:0] new_y;
	logic [8:0] py;
	logic [8:0] bx;
	logic [8:0] by;
	logic       pressed;

	always_comb begin
		dx = (fresh_x > held_x_q) ? (fresh_x - held_x_q) : (held_x_q - fresh_x);
		dy = (fresh_y > held_y_q) ? (fresh_y - held_y_q) : (held_y_q - fresh_y);
		new_x = (touch && (dx > {4'd0, deadband})) ? fresh_x : held_x_q;
		new_y = (touch && (dy > {5'd0, deadband})) ? fresh_y : held_y_q;
		py = Y_MAX - new_y;
		bx = landscape ? BOUND_LONG : BOUND_SHORT;
		by = landscape ? BOUND_SHORT : BOUND_LONG;
		pressed = touch && (new_x != 8'd0) && ({1'b0, new_x} < bx)
			&& (py != 9'd0) && (py < by);
		res.pos_x       = new_x;
		res.pos_y       = py;
		res.is_pressed  = pressed;
		res.was_pressed = pressed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q  <= '0;
			held_y_q  <= Y_MAX;
			pressed_q <= 1'b0;
		end else if (advance) begin
			held_x_q  <= new_x;
			held_y_q  <= new_y;
			pressed_q <= pressed;
		end
	end

endmodule
